>>> rtl/pfa_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the partition fit allocator
// no dependencies; used by the top level and the bench
package pfa_pkg;

  // command codes on the action port
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_RESTORE = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;

  // result codes on the status port
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  // search policies
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  // configuration register indexes
  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // fixed field widths
  localparam int ACTION_W  = 2;
  localparam int INDEX_W   = 4;
  localparam int FIELD_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int POLICY_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 5;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POLICY_W-1:0] policy_t;

endpackage

>>> rtl/pfa_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/partition_fit_allocator_unit.sv
`timescale 1ns / 1ps
// fixed-partition allocator: first, best or worst fit over stored partition sizes
// depends on pfa_pkg and pfa_ram
// load and restore beats: result strobe in the cycle after start, one beat per cycle while not busy
// request beats: the size ram is read one entry a cycle over L = min(block_count, MAX_BLOCKS)
//   entries; each entry is compared when its registered read data returns, then done is registered
// a request with L of zero answers in the cycle after start; busy is high during the scan only
// synchronous reset: sizes read as zero, all partitions free, first fit, 16 partitions
// results are strobed for one cycle by done; the receiver cannot stall
module partition_fit_allocator_unit #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [pfa_pkg::ACTION_W-1:0] action,
  input  logic [pfa_pkg::INDEX_W-1:0]  part_index,
  input  logic [pfa_pkg::FIELD_W-1:0]  part_size,
  input  logic [pfa_pkg::FIELD_W-1:0]  request_size,
  // result channel
  output logic                         done,
  output logic [pfa_pkg::STATUS_W-1:0] status,
  output logic [pfa_pkg::INDEX_W-1:0]  granted_block,
  // configuration port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state;
  pfa_pkg::policy_t      fit_policy;
  logic [pfa_pkg::COUNT_W-1:0] block_count;

  logic [MAX_BLOCKS-1:0] used;
  logic [MAX_BLOCKS-1:0] size_valid;

  logic [CW-1:0]         lim;
  logic [CW-1:0]         lim_r;
  logic [SIZE_BITS-1:0]  need_r;
  logic                  issuing;
  logic [IW-1:0]         scan_idx;
  logic                  chk_valid;
  logic [IW-1:0]         chk_idx;

  logic                  pick_found;
  logic [IW-1:0]         pick_idx;
  logic [SIZE_BITS-1:0]  pick_size;

  logic                  accept;
  logic                  load_ok;
  logic                  ram_we;
  logic                  ram_re;
  logic [SIZE_BITS-1:0]  ram_rdata;

  logic [SIZE_BITS-1:0]  sz;
  logic                  fit;
  logic                  take;
  logic                  last;
  logic                  final_found;
  logic [IW-1:0]         final_idx;

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;

  // partitions searched, capped at the storage depth
  always_comb begin
    if ({27'd0, block_count} >= 32'(MAX_BLOCKS)) begin
      lim = CW'(MAX_BLOCKS);
    end else begin
      lim = CW'(block_count);
    end
  end

  assign load_ok = ({28'd0, part_index} < 32'(MAX_BLOCKS));
  assign ram_we  = accept && (action == pfa_pkg::ACT_LOAD) && load_ok;
  assign ram_re  = issuing;

  // partition size storage
  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(part_index)),
    .wdata (SIZE_BITS'(part_size)),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // evaluate the entry whose read data has just come back
  always_comb begin
    sz   = size_valid[chk_idx] ? ram_rdata : '0;
    fit  = chk_valid && !used[chk_idx] && (sz >= need_r);
    take = fit && (!pick_found
           || ((fit_policy == pfa_pkg::POLICY_BEST) && (sz < pick_size))
           || ((fit_policy == pfa_pkg::POLICY_WORST) && (sz > pick_size)));
    last = chk_valid && (CW'(chk_idx) == (lim_r - CW'(1)));
    final_found = pick_found || take;
    final_idx   = take ? chk_idx : pick_idx;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= pfa_pkg::POLICY_FIRST;
      block_count <= pfa_pkg::COUNT_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::CFG_FIT_POLICY:  fit_policy  <= cfg_wdata[pfa_pkg::POLICY_W-1:0];
        pfa_pkg::CFG_BLOCK_COUNT: block_count <= cfg_wdata[pfa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control: sequencer, scan flags, partition flags and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issuing    <= 1'b0;
      chk_valid  <= 1'b0;
      pick_found <= 1'b0;
      done       <= 1'b0;
      used       <= '0;
      size_valid <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              pfa_pkg::ACT_LOAD: begin
                done <= 1'b1;
                if (load_ok) begin
                  size_valid[IW'(part_index)] <= 1'b1;
                end
              end
              pfa_pkg::ACT_RESTORE: begin
                done <= 1'b1;
                used <= '0;
              end
              pfa_pkg::ACT_REQUEST: begin
                if (lim == '0) begin
                  done <= 1'b1;
                end else begin
                  state      <= S_SCAN;
                  issuing    <= 1'b1;
                  pick_found <= 1'b0;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // read side: one address a cycle
          chk_valid <= issuing;
          if (issuing && (CW'(scan_idx) == (lim_r - CW'(1)))) begin
            issuing <= 1'b0;
          end
          // compare side
          pick_found <= final_found;
          if (last) begin
            state     <= S_IDLE;
            chk_valid <= 1'b0;
            done      <= 1'b1;
            if (final_found) begin
              used[final_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lim_r    <= lim;
      need_r   <= SIZE_BITS'(request_size);
      scan_idx <= '0;
    end else if (issuing) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (issuing) begin
      chk_idx <= scan_idx;
    end
    if (take) begin
      pick_idx  <= chk_idx;
      pick_size <= sz;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && (state == S_IDLE)) begin
      status        <= (action == pfa_pkg::ACT_REQUEST) ? pfa_pkg::ST_FAIL : pfa_pkg::ST_DONE;
      granted_block <= '0;
    end else if (last) begin
      status        <= final_found ? pfa_pkg::ST_GRANT : pfa_pkg::ST_FAIL;
      granted_block <= final_found ? pfa_pkg::INDEX_W'(final_idx) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // a refused or plain beat never carries a partition index
  a_grant_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != pfa_pkg::ST_GRANT)) |-> (granted_block == '0))
    else $error("granted_block set on a non-grant result");

  // every accepted beat either answers next cycle or starts a scan
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted beat neither answered nor scanning");

  // no result strobe while a scan is running
  a_no_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !done)
    else $error("result strobe during scan");

  // checked entries stay inside the searched range
  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (CW'(chk_idx) < lim_r))
    else $error("scan index beyond partition count");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// self-checking bench for partition_fit_allocator_unit: directed then random command beats
// depends on pfa_pkg and the allocator rtl; keeps its own copy of sizes, used flags and config
module tb;
  import pfa_pkg::*;

  // codes the package leaves unnamed
  localparam action_t ACT_UNUSED   = 2'd3;
  localparam policy_t POLICY_SPARE = 2'd3;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] block;
  } alloc_reply_t;

  // allocator state mirror and queue of outstanding replies
  class alloc_tracker;
    logic [FIELD_W-1:0] sizes [16];
    bit                 used [16];
    policy_t            policy;
    logic [COUNT_W-1:0] count;
    alloc_reply_t       replies [$];
    int                 mismatches;

    function new();
      policy = POLICY_FIRST;
      count = 5'd16;
      mismatches = 0;
      foreach (sizes[i]) begin
        sizes[i] = '0;
        used[i] = 1'b0;
      end
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_FIT_POLICY) begin
        policy = val[POLICY_W-1:0];
      end else begin
        count = val;
      end
    endfunction

    // chosen partition index, or -1 when nothing free is big enough
    function int search_fit(logic [FIELD_W-1:0] need);
      int lim;
      int pick;
      logic [FIELD_W-1:0] pick_sz;
      lim = (count > 16) ? 16 : int'(count);
      pick = -1;
      pick_sz = '0;
      for (int i = 0; i < lim; i++) begin
        if (used[i] || sizes[i] < need) continue;
        if (pick < 0) begin
          pick = i;
          pick_sz = sizes[i];
          if (policy != POLICY_BEST && policy != POLICY_WORST) break;
        end else if (policy == POLICY_BEST && sizes[i] < pick_sz) begin
          pick = i;
          pick_sz = sizes[i];
        end else if (policy == POLICY_WORST && sizes[i] > pick_sz) begin
          pick = i;
          pick_sz = sizes[i];
        end
      end
      return pick;
    endfunction

    function void note_command(action_t act, logic [INDEX_W-1:0] idx,
                               logic [FIELD_W-1:0] psz, logic [FIELD_W-1:0] rsz);
      alloc_reply_t r;
      int pick;
      r.status = ST_DONE;
      r.block = '0;
      case (act)
        ACT_LOAD: begin
          sizes[idx] = psz;
        end
        ACT_RESTORE: begin
          foreach (used[i]) used[i] = 1'b0;
        end
        ACT_REQUEST: begin
          pick = search_fit(rsz);
          if (pick < 0) begin
            r.status = ST_FAIL;
          end else begin
            used[pick] = 1'b1;
            r.status = ST_GRANT;
            r.block = pick[INDEX_W-1:0];
          end
        end
        default: ;
      endcase
      replies.push_back(r);
    endfunction

    function void check_reply(status_t st, logic [INDEX_W-1:0] blk);
      alloc_reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: status %0d block %0d",
                   $realtime, st, blk);
      end else begin
        want = replies.pop_front();
        if (st !== want.status || blk !== want.block) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected status %0d block %0d, got status %0d block %0d",
                     $realtime, want.status, want.block, st, blk);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  action_t action = ACT_LOAD;
  logic [INDEX_W-1:0] part_index = '0;
  logic [FIELD_W-1:0] part_size = '0;
  logic [FIELD_W-1:0] request_size = '0;
  logic done;
  status_t status;
  logic [INDEX_W-1:0] granted_block;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_FIT_POLICY;
  logic [CFG_W-1:0] cfg_wdata = '0;

  alloc_tracker tracker;
  int idle_pct = 0;
  int beats_sent = 0;

  always #5 clk = ~clk;

  partition_fit_allocator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .part_index    (part_index),
    .part_size     (part_size),
    .request_size  (request_size),
    .done          (done),
    .status        (status),
    .granted_block (granted_block),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // result beats are taken at the edge that closes the strobe cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_reply(status, granted_block);
  end

  // one command beat, with a random hold-off before it
  task automatic send_cmd(action_t act, logic [INDEX_W-1:0] idx,
                          logic [FIELD_W-1:0] psz, logic [FIELD_W-1:0] rsz);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct)
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    part_index <= idx;
    part_size <= psz;
    request_size <= rsz;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_command(act, idx, psz, rsz);
    beats_sent++;
  endtask

  // register write once every outstanding reply is back
  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    start <= 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(idx, val);
  endtask

  // sizes biased towards ties, zero and full scale
  function automatic logic [FIELD_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return FIELD_W'($urandom_range(0, 15));
      6, 7: return FIELD_W'($urandom_range(0, 300));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // mostly load-then-request bursts, some lone random beats
  task automatic random_burst();
    int n;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 2) == 0)
        send_cmd(ACT_RESTORE, INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) send_cmd(ACT_LOAD, INDEX_W'($urandom), pick_size(), FIELD_W'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) send_cmd(ACT_REQUEST, INDEX_W'($urandom), FIELD_W'($urandom), pick_size());
    end else begin
      send_cmd(action_t'($urandom_range(0, 3)), INDEX_W'($urandom),
               FIELD_W'($urandom), FIELD_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int target;
    logic [COUNT_W-1:0] cnt;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, zero sizes, used loads, unused code
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000);
    send_cmd(ACT_REQUEST, 4'hF, 16'hFFFF, 16'h0001);
    send_cmd(ACT_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_LOAD, 4'h0, 16'hFFFF, 16'h0000);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'hFFFF);
    send_cmd(ACT_RESTORE, 4'hF, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'hFFFF);
    send_cmd(ACT_LOAD, 4'hF, 16'hFFFF, 16'h0000);
    send_cmd(ACT_LOAD, 4'h7, 16'h0005, 16'h0000);
    send_cmd(ACT_LOAD, 4'h8, 16'h0005, 16'h0000);
    send_cmd(ACT_LOAD, 4'h9, 16'h0003, 16'h0000);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0003);

    // directed: best and worst fit with ties
    write_cfg(CFG_FIT_POLICY, CFG_W'(POLICY_BEST));
    send_cmd(ACT_RESTORE, 4'h0, 16'h0000, 16'h0000);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0003);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0004);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0004);
    write_cfg(CFG_FIT_POLICY, CFG_W'(POLICY_WORST));
    send_cmd(ACT_RESTORE, 4'h0, 16'h0000, 16'h0000);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000);

    // directed: spare policy code, empty and oversized partition counts
    write_cfg(CFG_FIT_POLICY, CFG_W'(POLICY_SPARE));
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0001);
    write_cfg(CFG_BLOCK_COUNT, 5'd0);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000);
    write_cfg(CFG_BLOCK_COUNT, 5'd31);
    send_cmd(ACT_REQUEST, 4'h0, 16'h0000, 16'h0000);

    // random phases: sender idles 13%, then 77%, then never
    for (int phase = 0; phase < 9; phase++) begin
      idle_pct = (phase < 3) ? 13 : (phase < 6) ? 77 : 0;
      case (phase)
        0: cnt = 5'd16;
        1: cnt = 5'd1;
        2: cnt = 5'd17;
        3: cnt = 5'd5;
        4: cnt = 5'd31;
        5: cnt = 5'd0;
        6: cnt = 5'd16;
        7: cnt = 5'd12;
        default: cnt = COUNT_W'($urandom_range(2, 16));
      endcase
      write_cfg(CFG_FIT_POLICY, CFG_W'(policy_t'(phase % 4)));
      write_cfg(CFG_BLOCK_COUNT, cnt);
      target = beats_sent + 45;
      while (beats_sent < target) random_burst();
    end

    // drain
    start <= 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
